/* rtl/nsfc_pkg.sv */
`timescale 1ns / 1ps

package nsfc_pkg;

  // Default depth of the line store, terminator included.
  localparam int LINE_DEPTH_DEF = 128;

  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;
  localparam int POS_W = 7;
  localparam int OUT_DATA_W = 32;

  // Characters with a special meaning.
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GOOD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_BODY = 3'b010,
    PH_SUM  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [BYTE_W-1:0]  running_xor;
    logic [BYTE_W-1:0]  parsed_sum;
  } frame_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   char_out;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   computed_sum;
    logic [BYTE_W-1:0]   received_sum;
  } frame_result_t;

  // Value of one hex digit; anything that is not a hex digit counts as zero.
  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = 4'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = 4'(ch - 8'h57);
    end
    return v;
  endfunction

endpackage

/* rtl/nsfc_step.sv */
`timescale 1ns / 1ps

module nsfc_step #(
  parameter int LINE_DEPTH = nsfc_pkg::LINE_DEPTH_DEF,
  parameter int LEN_W = $clog2(LINE_DEPTH + 1)
) (
  input  logic [nsfc_pkg::BYTE_W-1:0] byte_in,
  input  nsfc_pkg::frame_state_t      state_cur,
  input  logic [LEN_W-1:0]            len_cur,
  output nsfc_pkg::frame_state_t      state_nxt,
  output logic [LEN_W-1:0]            len_nxt,
  output nsfc_pkg::frame_result_t     result
);

  import nsfc_pkg::*;

  logic              term;
  logic              dollar;
  logic [BYTE_W-1:0] ch;
  phase_t            ph;
  logic [BYTE_W-1:0] xr;
  logic [LEN_W-1:0]  ln;
  logic              ignored;

  always_comb begin
    // CR, LF and a NUL byte all end the line and are stored as zero.
    term = (byte_in == CH_LF) || (byte_in == CH_CR) || (byte_in == CH_NUL);
    dollar = (byte_in == CH_DOLLAR);
    ch = term ? CH_NUL : byte_in;

    ph = dollar ? PH_BODY : state_cur.phase;
    xr = dollar ? '0 : state_cur.running_xor;
    ln = dollar ? '0 : len_cur;

    state_nxt.phase = ph;
    state_nxt.running_xor = xr;
    state_nxt.parsed_sum = state_cur.parsed_sum;
    len_nxt = ln;
    ignored = 1'b0;

    case (ph)
      PH_BODY: begin
        if (ch == CH_STAR) begin
          state_nxt.phase = PH_SUM;
          state_nxt.parsed_sum = '0;
        end else if (!dollar) begin
          state_nxt.running_xor = xr ^ ch;
        end
      end
      PH_SUM: begin
        // The low nibble is zero after the shift, so the add is a concatenation.
        if (!term) begin
          state_nxt.parsed_sum = {state_cur.parsed_sum[3:0], hex_value(ch)};
        end
      end
      default: begin
        ignored = 1'b1;
      end
    endcase

    result.computed_sum = state_nxt.running_xor;
    result.received_sum = state_nxt.parsed_sum;

    if (ignored) begin
      state_nxt.phase = PH_IDLE;
      result.status = ST_IGNORED;
      result.char_out = '0;
      result.position = '0;
    end else if (ln >= LEN_W'(LINE_DEPTH)) begin
      state_nxt.phase = PH_IDLE;
      len_nxt = '0;
      result.status = ST_OVERFLOW;
      result.char_out = ch;
      result.position = '0;
    end else begin
      len_nxt = ln + LEN_W'(1);
      result.char_out = ch;
      result.position = POS_W'(8'(ln));
      if (!term) begin
        result.status = ST_STORED;
      end else begin
        state_nxt.phase = PH_IDLE;
        len_nxt = '0;
        result.status = (state_nxt.running_xor == state_nxt.parsed_sum) ? ST_GOOD : ST_BAD;
      end
    end
  end

endmodule

/* rtl/nmea_sentence_framer_checksum.sv */
`timescale 1ns / 1ps
// Channel  Direction  tdata                                   tuser
// in_      input      byte_in[7:0]                            -
// out_     output     char_out, position, computed_sum,       status[2:0]
//                     received_sum (from bit 0 up, 32 bits)
//
// One byte per cycle while the output is not stalled: each transaction is processed in the
// cycle it is accepted and its result appears in the output register in the next cycle.
// The frame state update is combinational logic from the state registers.
// Reset sets the phase to idle and clears both sums, the line length and the output valid.
// A stalled output holds its result; input is taken whenever the output
// register is empty or is being emptied in the same cycle.

module nmea_sentence_framer_checksum #(
  parameter int LINE_DEPTH = nsfc_pkg::LINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nsfc_pkg::BYTE_W-1:0]       in_tdata,   // byte_in[7:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // char_out[7:0], position[14:8], computed_sum[22:15], received_sum[30:23], zero[31]
  output logic [nsfc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [nsfc_pkg::STATUS_W-1:0]     out_tuser   // status[2:0]
);

  import nsfc_pkg::*;

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  frame_state_t  state_r;
  frame_state_t  state_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  frame_result_t res_nxt;
  frame_result_t res_r;
  logic          out_valid_r;
  logic          in_fire;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_fire = in_tvalid && in_tready;

  nsfc_step #(
    .LINE_DEPTH(LINE_DEPTH),
    .LEN_W(LEN_W)
  ) u_step (
    .byte_in(in_tdata),
    .state_cur(state_r),
    .len_cur(len_r),
    .state_nxt(state_nxt),
    .len_nxt(len_nxt),
    .result(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= PH_IDLE;
      state_r.running_xor <= '0;
      state_r.parsed_sum <= '0;
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        len_r <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = res_r.status;
  assign out_tdata = {1'b0, res_r.received_sum, res_r.computed_sum,
                      res_r.position, res_r.char_out};

endmodule

/* rtl/nsfc_checker.sv */
`timescale 1ns / 1ps

module nsfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nsfc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [nsfc_pkg::STATUS_W-1:0]   out_tuser
);

  import nsfc_pkg::*;

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // Every accepted transaction yields a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

  // A good line has matching sums; a bad line does not.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tuser != ST_GOOD || out_tdata[22:15] == out_tdata[30:23]) &&
      (out_tuser != ST_BAD || out_tdata[22:15] != out_tdata[30:23]))
    else $error("line verdict disagrees with the sums");

  // An ignored byte carries neither a character nor a position.
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_IGNORED |-> out_tdata[14:0] == '0)
    else $error("ignored byte reported a character or position");

  // An overflow is reported at position zero.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OVERFLOW |-> out_tdata[14:8] == '0)
    else $error("overflow reported a nonzero position");

endmodule

bind nmea_sentence_framer_checksum nsfc_checker u_nsfc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
